/* src/jpeg_marker_segment_walker_defines.svh */
// ----------------------------------------------------------------------------
// JPEG marker segment walker - assertion macros
// Concurrent check macros clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef JPEG_MARKER_SEGMENT_WALKER_DEFINES_SVH
`define JPEG_MARKER_SEGMENT_WALKER_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define JMSW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("jmsw assertion failed");
// next-cycle implication
`define JMSW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("jmsw assertion failed");
`else
`define JMSW_ASSERT_NOW(lbl, ante, cons)
`define JMSW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* src/jmsw_pkg.sv */
// ----------------------------------------------------------------------------
// JPEG marker segment walker - package
// Marker codes, byte classes, parse phases and the word types between stages.
// ----------------------------------------------------------------------------
package jmsw_pkg;

    localparam logic [7:0] MK_PREFIX = 8'hff;
    localparam logic [7:0] MK_SOI    = 8'hd8;
    localparam logic [7:0] MK_EOI    = 8'hd9;
    localparam logic [7:0] MK_APP1   = 8'he1;
    localparam logic [7:0] MK_SOS    = 8'hda;
    localparam logic [7:0] MK_RST0   = 8'hd0;
    localparam logic [7:0] STUFF     = 8'h00;

    typedef enum logic [2:0] {
        CLS_FILL     = 3'd0,
        CLS_PREFIX   = 3'd1,
        CLS_MCODE    = 3'd2,
        CLS_LENGTH   = 3'd3,
        CLS_PAYLOAD  = 3'd4,
        CLS_ENTROPY  = 3'd5,
        CLS_AFTER    = 3'd6,
        CLS_NOT_JPEG = 3'd7
    } t_byte_class;

    typedef enum logic [9:0] {
        PH_SOI0    = 10'b00_0000_0001,
        PH_SOI1    = 10'b00_0000_0010,
        PH_FILL    = 10'b00_0000_0100,
        PH_MCODE   = 10'b00_0000_1000,
        PH_ENT     = 10'b00_0001_0000,
        PH_ENT_FF  = 10'b00_0010_0000,
        PH_LEN_HI  = 10'b00_0100_0000,
        PH_LEN_LO  = 10'b00_1000_0000,
        PH_PAYLOAD = 10'b01_0000_0000,
        PH_DONE    = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  byte_out;
        t_byte_class byte_class;
        logic [7:0]  segment_marker;
        logic        app1_payload;
        logic        segment_last;
        logic        end_of_image;
        logic        length_error;
    } t_result;

    // phase that follows a marker code byte
    function automatic t_phase marker_next(input logic [7:0] code);
        t_phase ph;
        if (code == MK_EOI) begin
            ph = PH_DONE;
        end else if (code inside {[MK_RST0:MK_SOI], MK_SOS}) begin
            ph = PH_ENT;
        end else begin
            ph = PH_LEN_HI;
        end
        return ph;
    endfunction

endpackage

/* src/jmsw_stream_if.sv */
// ----------------------------------------------------------------------------
// JPEG marker segment walker - stream interfaces
// Valid/ready channels for input bytes and classified result words.
// ----------------------------------------------------------------------------
interface jmsw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_file;

    modport source (output valid, output data_byte, output start_of_file, input ready);
    modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface jmsw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [2:0] byte_class;
    logic [7:0] segment_marker;
    logic       app1_payload;
    logic       segment_last;
    logic       end_of_image;
    logic       length_error;

    modport source (
        output valid, output byte_out, output byte_class, output segment_marker,
        output app1_payload, output segment_last, output end_of_image,
        output length_error, input ready
    );
    modport sink (
        input valid, input byte_out, input byte_class, input segment_marker,
        input app1_payload, input segment_last, input end_of_image,
        input length_error, output ready
    );
endinterface

/* src/jmsw_in_stage.sv */
// ----------------------------------------------------------------------------
// JPEG marker segment walker - input register
// Captures one input word per cycle; holds it while the next stage stalls.
// ----------------------------------------------------------------------------
module jmsw_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  jmsw_pkg::t_in_word i_word,
    output logic               o_valid,
    input  logic               i_ready,
    output jmsw_pkg::t_in_word o_word
);
    logic               r_valid;
    logic               n_valid;
    jmsw_pkg::t_in_word r_word;

    assign o_ready = !r_valid || i_ready;
    assign n_valid = i_valid || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
endmodule

/* src/jmsw_classify.sv */
// ----------------------------------------------------------------------------
// JPEG marker segment walker - byte classifier
// Parse state and the combinational classification of one byte.
// ----------------------------------------------------------------------------
module jmsw_classify (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  jmsw_pkg::t_in_word i_word,
    output logic               o_valid,
    input  logic               i_ready,
    output jmsw_pkg::t_result  o_result
);
    jmsw_pkg::t_phase r_phase, n_phase, e_phase;
    logic [7:0]       r_marker, n_marker, e_marker;
    logic [7:0]       r_len_hi, n_len_hi, e_len_hi;
    logic [15:0]      r_rem, n_rem, e_rem;
    logic             r_nj, n_nj, e_nj;
    logic [15:0]      rem_dec;
    logic [15:0]      len;
    logic [7:0]       b;
    logic             advance;

    jmsw_pkg::t_byte_class cls;
    logic app1, last, eoi, lerr;

    assign b       = i_word.data_byte;
    assign advance = i_valid && i_ready;
    assign o_ready = i_ready;
    assign o_valid = i_valid;
    assign rem_dec = e_rem - 16'd1;
    assign len     = {e_len_hi, b};

    always_comb begin
        if (i_word.start_of_file) begin
            e_phase  = jmsw_pkg::PH_SOI0;
            e_marker = 8'd0;
            e_len_hi = 8'd0;
            e_rem    = 16'd0;
            e_nj     = 1'b0;
        end else begin
            e_phase  = r_phase;
            e_marker = r_marker;
            e_len_hi = r_len_hi;
            e_rem    = r_rem;
            e_nj     = r_nj;
        end

        n_phase  = e_phase;
        n_marker = e_marker;
        n_len_hi = e_len_hi;
        n_rem    = e_rem;
        n_nj     = e_nj;
        cls      = jmsw_pkg::CLS_FILL;
        app1     = 1'b0;
        last     = 1'b0;
        eoi      = 1'b0;
        lerr     = 1'b0;

        if (e_nj) begin
            cls = jmsw_pkg::CLS_NOT_JPEG;
        end else begin
            case (e_phase)
                jmsw_pkg::PH_SOI0: begin
                    if (b == jmsw_pkg::MK_PREFIX) begin
                        cls     = jmsw_pkg::CLS_PREFIX;
                        n_phase = jmsw_pkg::PH_SOI1;
                    end else begin
                        cls  = jmsw_pkg::CLS_NOT_JPEG;
                        n_nj = 1'b1;
                    end
                end
                jmsw_pkg::PH_SOI1: begin
                    if (b == jmsw_pkg::MK_SOI) begin
                        cls      = jmsw_pkg::CLS_MCODE;
                        n_marker = b;
                        n_phase  = jmsw_pkg::marker_next(b);
                    end else begin
                        cls  = jmsw_pkg::CLS_NOT_JPEG;
                        n_nj = 1'b1;
                    end
                end
                jmsw_pkg::PH_MCODE: begin
                    cls      = jmsw_pkg::CLS_MCODE;
                    n_marker = b;
                    n_phase  = jmsw_pkg::marker_next(b);
                    eoi      = (b == jmsw_pkg::MK_EOI);
                end
                jmsw_pkg::PH_ENT: begin
                    cls = jmsw_pkg::CLS_ENTROPY;
                    if (b == jmsw_pkg::MK_PREFIX) begin
                        n_phase = jmsw_pkg::PH_ENT_FF;
                    end
                end
                jmsw_pkg::PH_ENT_FF: begin
                    if (b == jmsw_pkg::STUFF) begin
                        cls     = jmsw_pkg::CLS_ENTROPY;
                        n_phase = jmsw_pkg::PH_ENT;
                    end else begin
                        cls      = jmsw_pkg::CLS_MCODE;
                        n_marker = b;
                        n_phase  = jmsw_pkg::marker_next(b);
                        eoi      = (b == jmsw_pkg::MK_EOI);
                    end
                end
                jmsw_pkg::PH_LEN_HI: begin
                    cls      = jmsw_pkg::CLS_LENGTH;
                    n_len_hi = b;
                    n_phase  = jmsw_pkg::PH_LEN_LO;
                end
                jmsw_pkg::PH_LEN_LO: begin
                    cls = jmsw_pkg::CLS_LENGTH;
                    if (len < 16'd2) begin
                        lerr    = 1'b1;
                        n_phase = jmsw_pkg::PH_FILL;
                    end else if (len == 16'd2) begin
                        n_phase = jmsw_pkg::PH_FILL;
                    end else begin
                        n_rem   = len - 16'd2;
                        n_phase = jmsw_pkg::PH_PAYLOAD;
                    end
                end
                jmsw_pkg::PH_PAYLOAD: begin
                    cls   = jmsw_pkg::CLS_PAYLOAD;
                    app1  = (e_marker == jmsw_pkg::MK_APP1);
                    n_rem = rem_dec;
                    if (rem_dec == 16'd0) begin
                        last    = 1'b1;
                        n_phase = jmsw_pkg::PH_FILL;
                    end
                end
                jmsw_pkg::PH_DONE: begin
                    cls = jmsw_pkg::CLS_AFTER;
                end
                default: begin
                    if (b == jmsw_pkg::MK_PREFIX) begin
                        cls     = jmsw_pkg::CLS_PREFIX;
                        n_phase = jmsw_pkg::PH_MCODE;
                    end else begin
                        cls     = jmsw_pkg::CLS_FILL;
                        n_phase = jmsw_pkg::PH_FILL;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= jmsw_pkg::PH_SOI0;
            r_marker <= 8'd0;
            r_len_hi <= 8'd0;
            r_rem    <= 16'd0;
            r_nj     <= 1'b0;
        end else if (advance) begin
            r_phase  <= n_phase;
            r_marker <= n_marker;
            r_len_hi <= n_len_hi;
            r_rem    <= n_rem;
            r_nj     <= n_nj;
        end
    end

    always_comb begin
        o_result.byte_out       = b;
        o_result.byte_class     = cls;
        o_result.segment_marker = n_marker;
        o_result.app1_payload   = app1;
        o_result.segment_last   = last;
        o_result.end_of_image   = eoi;
        o_result.length_error   = lerr;
    end
endmodule

/* src/jmsw_out_stage.sv */
// ----------------------------------------------------------------------------
// JPEG marker segment walker - result register
// Holds one classified word until the sink takes it.
// ----------------------------------------------------------------------------
module jmsw_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  jmsw_pkg::t_result i_result,
    output logic              o_valid,
    input  logic              i_ready,
    output jmsw_pkg::t_result o_result
);
    logic              r_valid;
    logic              n_valid;
    jmsw_pkg::t_result r_result;

    assign o_ready = !r_valid || i_ready;
    assign n_valid = i_valid || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

/* src/jpeg_marker_segment_walker.sv */
// ----------------------------------------------------------------------------
// JPEG marker segment walker - top level
// Classifies each byte of a JPEG stream by its place in the marker structure.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the sink keeps up, and one result word
// comes out per byte, in order, through the input and result registers.
// The byte goes through an input register, is classified against the parse
// state combinationally (state update and the 16-bit payload count-down),
// and lands in a result register; both registers keep accepting while the
// next one has room. start_of_file on a byte restarts the parse at that byte.
module jpeg_marker_segment_walker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    jmsw_in_if.sink           i_in,
    jmsw_out_if.source        o_out
);
`include "jpeg_marker_segment_walker_defines.svh"

    jmsw_pkg::t_in_word in_word, st_word;
    jmsw_pkg::t_result  cl_result, out_result;
    logic st_valid, st_ready;
    logic cl_valid, cl_ready;

    assign in_word.data_byte     = i_in.data_byte;
    assign in_word.start_of_file = i_in.start_of_file;

    jmsw_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_word  (in_word),
        .o_valid (st_valid),
        .i_ready (st_ready),
        .o_word  (st_word)
    );

    jmsw_classify u_cls (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (st_valid),
        .o_ready  (st_ready),
        .i_word   (st_word),
        .o_valid  (cl_valid),
        .i_ready  (cl_ready),
        .o_result (cl_result)
    );

    jmsw_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (cl_valid),
        .o_ready  (cl_ready),
        .i_result (cl_result),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_result (out_result)
    );

    assign o_out.byte_out       = out_result.byte_out;
    assign o_out.byte_class     = out_result.byte_class;
    assign o_out.segment_marker = out_result.segment_marker;
    assign o_out.app1_payload   = out_result.app1_payload;
    assign o_out.segment_last   = out_result.segment_last;
    assign o_out.end_of_image   = out_result.end_of_image;
    assign o_out.length_error   = out_result.length_error;

    `JMSW_ASSERT_NOW(a_eoi_code, cl_valid && cl_result.end_of_image, cl_result.byte_out == jmsw_pkg::MK_EOI && cl_result.byte_class == jmsw_pkg::CLS_MCODE)
    `JMSW_ASSERT_NOW(a_app1_payload, cl_valid && cl_result.app1_payload, cl_result.segment_marker == jmsw_pkg::MK_APP1 && cl_result.byte_class == jmsw_pkg::CLS_PAYLOAD)
    `JMSW_ASSERT_NOW(a_last_payload, cl_valid && cl_result.segment_last, cl_result.byte_class == jmsw_pkg::CLS_PAYLOAD)
    `JMSW_ASSERT_NEXT(a_result_taken, cl_valid && cl_ready, o_out.valid && out_result == $past(cl_result))
endmodule
